// File: hw/rtl/sorted_group_by_aggregator_assert.svh
// ----------------------------------------------------------------------------
// Sorted group-by aggregator assertion macros
// Concurrent checks on the block's clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SORTED_GROUP_BY_AGGREGATOR_ASSERT_SVH
`define SORTED_GROUP_BY_AGGREGATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge.
`define SGBA_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When pre holds, post holds in the same cycle.
`define SGBA_ASSERT_IMPLY(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// When pre holds, post holds in the next cycle.
`define SGBA_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define SGBA_ASSERT_ALWAYS(lbl, cond, msg)
`define SGBA_ASSERT_IMPLY(lbl, pre, post, msg)
`define SGBA_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// File: hw/rtl/sgba_pkg.sv
// ----------------------------------------------------------------------------
// Sorted group-by aggregator package
// Shared widths, codes and transaction types of the group-by block.
// ----------------------------------------------------------------------------
package sgba_pkg;

   localparam int DATA_W           = 32;
   localparam int PHYS_SLOTS       = 4;
   localparam int PHYS_COLUMNS     = 4;
   localparam int SEL_W            = 2;
   localparam int CODE_W           = 2;
   localparam int ACTIVE_W         = 3;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 8;
   localparam int QUEUE_DEPTH      = 2;
   localparam int DEF_SLOT_COUNT   = 4;
   localparam int DEF_COLUMN_COUNT = 4;

   typedef enum logic [CODE_W-1:0] {
      AGG_SUM   = 2'd0,
      AGG_CNT   = 2'd1,
      AGG_MIN   = 2'd2,
      AGG_MAX   = 2'd3
   } agg_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_COLUMN     = 2'd0,
      CSR_FUNCTION_CODES = 2'd1,
      CSR_SOURCE_COLUMNS = 2'd2,
      CSR_ACTIVE_SLOTS   = 2'd3
   } csr_index_type;

   typedef logic [PHYS_SLOTS-1:0][DATA_W-1:0]   slot_vec_type;
   typedef logic [PHYS_COLUMNS-1:0][DATA_W-1:0] row_type;

   typedef struct packed {
      logic [SEL_W-1:0]             key_column;
      logic [PHYS_SLOTS*CODE_W-1:0] function_codes;
      logic [PHYS_SLOTS*SEL_W-1:0]  source_columns;
      logic [ACTIVE_W-1:0]          active_slots;
   } cfg_type;

   // One classified row on its way from the front part to the back part.
   typedef struct packed {
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] closed_key;
      slot_vec_type      vals;
      logic              close_prev;
      logic              first;
      logic              final_row;
   } entry_type;

endpackage

// File: hw/rtl/sorted_group_by_aggregator.sv
// Timing: a row that closes a group is registered in the queue and its result in the
// output register; a row that also ends the table gives its second result after the first.
// Throughput: one row per cycle, set by the combinational slot fold in the back part, while
// the output is not stalled; a row closing two groups holds the back part for both results.
// Reset (synchronous, active high) clears the open group, aggregates, queue and output,
// and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// Sorted group-by aggregator
// Streaming group-by over key-sorted rows with up to four sum, count, min or
// max slots, emitting one transaction per finished group.
// ----------------------------------------------------------------------------
module sorted_group_by_aggregator
   import sgba_pkg::*;
#(
   parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
   parameter int COLUMN_COUNT = DEF_COLUMN_COUNT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_W-1:0]     req_column_a,
   input  logic signed [DATA_W-1:0]     req_column_b,
   input  logic signed [DATA_W-1:0]     req_column_c,
   input  logic signed [DATA_W-1:0]     req_column_d,
   input  logic                         req_final_row,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_W-1:0]     rsp_group_key,
   output logic signed [DATA_W-1:0]     rsp_result_0,
   output logic signed [DATA_W-1:0]     rsp_result_1,
   output logic signed [DATA_W-1:0]     rsp_result_2,
   output logic signed [DATA_W-1:0]     rsp_result_3,
   output logic                         rsp_table_done,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   cfg_type           cfg_ff, cfg_in;
   row_type           row;
   logic              full;
   logic              push;
   entry_type         push_entry;
   logic              pop;
   logic              head_valid;
   entry_type         head;
   logic [DATA_W-1:0] group_key;
   slot_vec_type      results;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_COLUMN:     cfg_in.key_column     = csr_data[SEL_W-1:0];
            CSR_FUNCTION_CODES: cfg_in.function_codes = csr_data[PHYS_SLOTS*CODE_W-1:0];
            CSR_SOURCE_COLUMNS: cfg_in.source_columns = csr_data[PHYS_SLOTS*SEL_W-1:0];
            CSR_ACTIVE_SLOTS:   cfg_in.active_slots   = csr_data[ACTIVE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_column     <= '0;
         cfg_ff.function_codes <= '0;
         cfg_ff.source_columns <= '0;
         cfg_ff.active_slots   <= ACTIVE_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign row[0] = req_column_a;
   assign row[1] = req_column_b;
   assign row[2] = req_column_c;
   assign row[3] = req_column_d;

   sgba_front #(
      .COLUMN_COUNT (COLUMN_COUNT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .row           (row),
      .req_final_row (req_final_row),
      .cfg           (cfg_ff),
      .full          (full),
      .push          (push),
      .entry         (push_entry)
   );

   sgba_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .full       (full)
   );

   sgba_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_group_key  (group_key),
      .rsp_results    (results),
      .rsp_table_done (rsp_table_done)
   );

   assign rsp_group_key = group_key;
   assign rsp_result_0  = results[0];
   assign rsp_result_1  = results[1];
   assign rsp_result_2  = results[2];
   assign rsp_result_3  = results[3];

endmodule

// File: hw/rtl/sgba_front.sv
// ----------------------------------------------------------------------------
// Sorted group-by aggregator front part
// Accepts rows, picks the key and slot source columns, and classifies each row
// against the open group before handing it to the queue.
// ----------------------------------------------------------------------------
module sgba_front
   import sgba_pkg::*;
#(
   parameter int COLUMN_COUNT = DEF_COLUMN_COUNT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  row_type   row,
   input  logic      req_final_row,
   input  cfg_type   cfg,
   input  logic      full,
   output logic      push,
   output entry_type entry
);

   localparam int COL_LIMIT = (COLUMN_COUNT < PHYS_COLUMNS) ? COLUMN_COUNT : PHYS_COLUMNS;

   logic [DATA_W-1:0] open_key_ff, open_key_in;
   logic              open_ff, open_in;
   row_type           visible;
   logic [DATA_W-1:0] key;
   logic              close_prev;

   // Columns beyond the configured row width read as zero.
   always_comb begin
      for (int c = 0; c < PHYS_COLUMNS; c++) begin
         visible[c] = (c < COL_LIMIT) ? row[c] : '0;
      end
   end

   assign key        = visible[cfg.key_column];
   assign close_prev = open_ff && (key != open_key_ff);
   assign req_stall  = full;
   assign push       = req_valid && !full;

   always_comb begin
      entry.key        = key;
      entry.closed_key = open_key_ff;
      entry.close_prev = close_prev;
      entry.first      = !open_ff || close_prev;
      entry.final_row  = req_final_row;
      for (int s = 0; s < PHYS_SLOTS; s++) begin
         entry.vals[s] = visible[cfg.source_columns[SEL_W*s +: SEL_W]];
      end
   end

   always_comb begin
      open_key_in = open_key_ff;
      open_in     = open_ff;
      if (push) begin
         open_key_in = key;
         open_in     = !req_final_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= 1'b0;
         open_key_ff <= '0;
      end else begin
         open_ff     <= open_in;
         open_key_ff <= open_key_in;
      end
   end

endmodule

// File: hw/rtl/sgba_queue.sv
// ----------------------------------------------------------------------------
// Sorted group-by aggregator queue
// Short flop-based FIFO of classified rows between the front and back parts.
// ----------------------------------------------------------------------------
`include "sorted_group_by_aggregator_assert.svh"

module sgba_queue
   import sgba_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head,
   output logic      full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head       = store_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `SGBA_ASSERT_ALWAYS(a_no_overflow, !(push && full), "queue written while full")
   `SGBA_ASSERT_ALWAYS(a_no_underflow, !(pop && !head_valid), "queue read while empty")
   `SGBA_ASSERT_ALWAYS(a_count_range, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// File: hw/rtl/sgba_back.sv
// ----------------------------------------------------------------------------
// Sorted group-by aggregator back part
// Folds queued rows into the aggregate slots and emits finished groups through
// an output register. A row that closes two groups is held here until both are emitted.
// ----------------------------------------------------------------------------
`include "sorted_group_by_aggregator_assert.svh"

module sgba_back
   import sgba_pkg::*;
#(
   parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              head_valid,
   input  entry_type         head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_group_key,
   output slot_vec_type      rsp_results,
   output logic              rsp_table_done
);

   localparam int SLOT_LIMIT = (SLOT_COUNT < PHYS_SLOTS) ? SLOT_COUNT : PHYS_SLOTS;

   slot_vec_type      slots_ff, slots_in;
   slot_vec_type      folded;
   slot_vec_type      masked_cur, masked_fold;
   logic [PHYS_SLOTS-1:0] slot_en;
   logic              phase_ff, phase_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] key_ff, key_in;
   slot_vec_type      res_ff, res_in;
   logic              done_ff, done_in;
   logic              out_free;
   logic              need_emit;
   logic              step;
   logic              emit_now;

   always_comb begin
      for (int s = 0; s < PHYS_SLOTS; s++) begin
         slot_en[s] = (s < SLOT_LIMIT) && (ACTIVE_W'(s) < cfg.active_slots);
      end
   end

   // Per-slot fold of the head row; a group's first row seeds every enabled slot and clears the others.
   always_comb begin
      agg_type           code;
      logic [DATA_W-1:0] v;
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] f;
      for (int s = 0; s < PHYS_SLOTS; s++) begin
         code = agg_type'(cfg.function_codes[CODE_W*s +: CODE_W]);
         v    = head.vals[s];
         acc  = slots_ff[s];
         unique case (code)
            AGG_SUM:   f = head.first ? v : acc + v;
            AGG_CNT:   f = head.first ? DATA_W'(1) : acc + DATA_W'(1);
            AGG_MIN:   f = (head.first || ($signed(v) < $signed(acc))) ? v : acc;
            AGG_MAX:   f = (head.first || ($signed(v) > $signed(acc))) ? v : acc;
            default:   f = acc;
         endcase
         if (slot_en[s]) begin
            folded[s] = f;
         end else begin
            folded[s] = head.first ? '0 : acc;
         end
         masked_cur[s]  = slot_en[s] ? slots_ff[s] : '0;
         masked_fold[s] = slot_en[s] ? folded[s] : '0;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign need_emit = phase_ff || head.close_prev || head.final_row;
   assign step      = head_valid && (out_free || !need_emit);
   assign emit_now  = step && need_emit;

   always_comb begin
      slots_in = slots_ff;
      phase_in = phase_ff;
      key_in   = key_ff;
      res_in   = res_ff;
      done_in  = done_ff;
      pop      = 1'b0;
      if (step) begin
         priority if (phase_ff) begin
            // Second transaction of a row that both changed the key and ended the table.
            key_in   = head.key;
            res_in   = masked_cur;
            done_in  = 1'b1;
            slots_in = '0;
            phase_in = 1'b0;
            pop      = 1'b1;
         end else if (head.close_prev) begin
            key_in   = head.closed_key;
            res_in   = masked_cur;
            done_in  = 1'b0;
            slots_in = folded;
            phase_in = head.final_row;
            pop      = !head.final_row;
         end else begin
            slots_in = folded;
            pop      = 1'b1;
            if (head.final_row) begin
               key_in   = head.key;
               res_in   = masked_fold;
               done_in  = 1'b1;
               slots_in = '0;
            end
         end
      end
      for (int s = SLOT_LIMIT; s < PHYS_SLOTS; s++) begin
         slots_in[s] = '0;
      end
      rsp_valid_in = emit_now ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         slots_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         slots_ff     <= slots_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      res_ff  <= res_in;
      done_ff <= done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_group_key  = key_ff;
   assign rsp_results    = res_ff;
   assign rsp_table_done = done_ff;

   `SGBA_ASSERT_IMPLY(a_phase_entry, phase_ff,
                      head_valid && head.close_prev && head.final_row,
                      "second emission pending without a matching queued row")
   `SGBA_ASSERT_IMPLY(a_close_seeds, head_valid && head.close_prev, head.first,
                      "row closing a group does not start a new one")
   `SGBA_ASSERT_NEXT(a_final_clears, pop && head.final_row, slots_ff == '0,
                     "aggregate slots not cleared after the final row")

endmodule
